[rtl/aging_page_replacement_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef AGING_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define APR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

// Consequent checked in the same cycle as the antecedent.
`define APR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

`endif

[rtl/apr_pkg.sv]
package apr_pkg;

	localparam int NUM_PAGES_DEF    = 32;
	localparam int COUNTER_BITS_DEF = 8;
	localparam int MASK_BITS        = 32;
	localparam int VICTIM_W         = 5;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

[rtl/aging_page_replacement_unit.sv]
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// request  | in_valid, in_ready, req_type, used_mask  | in
// result   | out_valid, out_ready, victim_page        | out
//
// A tick updates all counters at once.
// A query reads one bit of every counter per cycle in ST_SEARCH, MSB first; ST_DONE then
// picks the lowest surviving page and loads the output register once that register is free.
// Reset clears all counters and the output register; a stalled result blocks only
// the end of the next query, and ticks are still taken until that query is accepted.
module aging_page_replacement_unit
	import apr_pkg::*;
#(
	parameter int NUM_PAGES    = NUM_PAGES_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [31:0]         used_mask,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VICTIM_W-1:0] victim_page
);

	localparam int CW = $clog2(COUNTER_BITS);
	localparam int IW = ($clog2(NUM_PAGES) > VICTIM_W) ? $clog2(NUM_PAGES) : VICTIM_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [COUNTER_BITS-1:0] age_q [NUM_PAGES];
	logic [NUM_PAGES-1:0]    cand_q;
	logic [CW-1:0]           bit_q;
	logic                    out_valid_q;
	logic [VICTIM_W-1:0]     victim_q;

	logic                    accept;
	logic                    tick;
	logic [NUM_PAGES-1:0]    msb;
	logic [NUM_PAGES-1:0]    zero_set;
	logic [NUM_PAGES-1:0]    onehot;
	logic [IW-1:0]           idx;
	logic                    load_out;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign tick        = accept && (req_type == REQ_TICK);
	assign out_valid   = out_valid_q;
	assign victim_page = victim_q;
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		for (int p = 0; p < NUM_PAGES; p++) begin
			msb[p] = age_q[p][COUNTER_BITS-1];
		end
		zero_set = cand_q & ~msb;
		onehot   = cand_q & (~cand_q + NUM_PAGES'(1));
		idx      = '0;
		for (int p = 0; p < NUM_PAGES; p++) begin
			if (onehot[p]) begin
				idx = idx | IW'(p);
			end
		end
	end

	// Counters rotate left during a search so the MSB of each is read in turn;
	// after COUNTER_BITS rotations they are back in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				age_q[p] <= '0;
			end
		end else if (tick) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				if (p < MASK_BITS) begin
					age_q[p] <= {used_mask[p % MASK_BITS], age_q[p][COUNTER_BITS-1:1]};
				end else begin
					age_q[p] <= {1'b0, age_q[p][COUNTER_BITS-1:1]};
				end
			end
		end else if (state_q == ST_SEARCH) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				age_q[p] <= {age_q[p][COUNTER_BITS-2:0], age_q[p][COUNTER_BITS-1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cand_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			victim_q    <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_QUERY)) begin
						cand_q  <= '1;
						bit_q   <= CW'(COUNTER_BITS - 1);
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (|zero_set) begin
						cand_q <= zero_set;
					end
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - CW'(1);
					end
				end
				ST_DONE: begin
					if (load_out) begin
						victim_q <= idx[VICTIM_W-1:0];
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/apr_checker.sv]
`include "aging_page_replacement_unit_defines.svh"

module apr_checker
	import apr_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                req_type,
	input logic                out_valid,
	input logic                out_ready,
	input logic [VICTIM_W-1:0] victim_page
);

	logic tick_take;
	logic query_take;

	assign tick_take  = in_valid && in_ready && (req_type == REQ_TICK);
	assign query_take = in_valid && in_ready && (req_type == REQ_QUERY);

	`APR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(victim_page))
	`APR_ASSERT_NEXT(a_tick_no_result, clk, arst_n, tick_take && !out_valid, !out_valid)
	`APR_ASSERT_NEXT(a_query_busy, clk, arst_n, query_take, !in_ready)
	`APR_ASSERT_NOW(a_result_after_search, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind aging_page_replacement_unit apr_checker u_apr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.req_type    (req_type),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.victim_page (victim_page)
);

[tb/aging_page_replacement_unit_tb.sv]
module aging_page_replacement_unit_tb;
	import apr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES    = NUM_PAGES_DEF;
	localparam int COUNTER_BITS = COUNTER_BITS_DEF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int STALL_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic                req;
		logic [31:0]         mask;
		logic                typed;
		logic [VICTIM_W-1:0] victim;
	} stim_row_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                req_type    = REQ_TICK;
	logic [31:0]         used_mask   = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [VICTIM_W-1:0] victim_page;

	logic [COUNTER_BITS-1:0] page_age [NUM_PAGES];
	logic [VICTIM_W-1:0]     victim_q [$];

	int idle_pct     = 28;
	int mismatches   = 0;
	int tick_count   = 0;
	int query_count  = 0;
	int result_count = 0;
	int stall_cycles = 0;

	stim_row_t directed_rows [25] = '{
		'{REQ_QUERY, 32'h0000_0000, 1'b1, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_QUERY, 32'h0000_0000, 1'b1, 5'd0},
		'{REQ_TICK,  32'h7FFF_FFFF, 1'b0, 5'd0},
		'{REQ_QUERY, 32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hAAAA_AAAA, 1'b0, 5'd0},
		'{REQ_QUERY, 32'h5555_5555, 1'b0, 5'd0},
		'{REQ_TICK,  32'h5555_5555, 1'b0, 5'd0},
		'{REQ_QUERY, 32'hAAAA_AAAA, 1'b0, 5'd0},
		'{REQ_TICK,  32'h0000_0001, 1'b0, 5'd0},
		'{REQ_TICK,  32'h8000_0000, 1'b0, 5'd0},
		'{REQ_QUERY, 32'h0000_0000, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_QUERY, 32'h0000_0000, 1'b1, 5'd0},
		'{REQ_TICK,  32'hFFFE_FFFF, 1'b0, 5'd0},
		'{REQ_QUERY, 32'hFFFF_FFFF, 1'b0, 5'd0},
		'{REQ_TICK,  32'h0000_0000, 1'b0, 5'd0},
		'{REQ_QUERY, 32'h0000_0000, 1'b0, 5'd0}
	};

	aging_page_replacement_unit #(
		.NUM_PAGES   (NUM_PAGES),
		.COUNTER_BITS(COUNTER_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.used_mask  (used_mask),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.victim_page(victim_page)
	);

	always #6 clk = ~clk;

	function automatic void age_pages(input logic [31:0] mask);
		logic used;
		for (int p = 0; p < NUM_PAGES; p++) begin
			used = (p < MASK_BITS) ? mask[p] : 1'b0;
			page_age[p] = {used, page_age[p][COUNTER_BITS-1:1]};
		end
	endfunction

	function automatic logic [VICTIM_W-1:0] oldest_page();
		int best;
		best = 0;
		for (int p = 1; p < NUM_PAGES; p++) begin
			if (page_age[p] < page_age[best]) begin
				best = p;
			end
		end
		return best[VICTIM_W-1:0];
	endfunction

	function automatic logic [31:0] random_mask();
		int k;
		k = $urandom_range(0, 31);
		case ($urandom_range(0, 7))
			0, 1: return $urandom();
			2: return '1;
			3: return '0;
			4: return 32'h1 << k;
			5: return ~(32'h1 << k);
			6: return $urandom() & $urandom() & $urandom();
			default: return {8{4'($urandom())}};
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t ns: %s", $realtime, what);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic offer_request(input logic req, input logic [31:0] mask,
			input logic typed, input logic [VICTIM_W-1:0] victim);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid  <= 1'b0;
			req_type  <= 1'($urandom());
			used_mask <= $urandom();
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		used_mask <= mask;
		do @(posedge clk); while (!in_ready);
		if (req == REQ_TICK) begin
			age_pages(mask);
			tick_count++;
		end else begin
			victim_q.push_back(typed ? victim : oldest_page());
			query_count++;
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin : check_results
		logic [VICTIM_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (victim_q.size() == 0) begin
				report_mismatch($sformatf("victim_page %0d with no query waiting",
					victim_page));
			end else begin
				want = victim_q.pop_front();
				if (victim_page !== want) begin
					report_mismatch($sformatf("victim_page expected %0d, got %0d",
						want, victim_page));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("No handshake for %0d cycles.", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		logic req;
		for (int p = 0; p < NUM_PAGES; p++) begin
			page_age[p] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i].req, directed_rows[i].mask,
				directed_rows[i].typed, directed_rows[i].victim);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_pct = (i >= 500 && i < 750) ? 0 : 28;
			req = ($urandom_range(0, 99) < 35) ? REQ_QUERY : REQ_TICK;
			offer_request(req, random_mask(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		idle_pct = 28;
		wait (victim_q.size() == 0);
		repeat (COUNTER_BITS + 4) @(posedge clk);
		$display("Sent %0d aging ticks and %0d victim queries; %0d victims checked.",
			tick_count, query_count, result_count);
		$display("Both channels ran with random gaps and one gap-free stretch.");
		if (mismatches == 0 && victim_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d victims missing.", mismatches, victim_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/apr_pkg.sv
rtl/aging_page_replacement_unit.sv
rtl/apr_checker.sv
tb/aging_page_replacement_unit_tb.sv
